@@ rtl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// pst_pkg
// shared types, constants and helpers of the peer session table
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BITS  = 4;
	localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);
	localparam int ID_BITS    = 32;
	localparam int WORD_BITS  = 32;
	localparam int SEC_BITS   = 64;

	localparam logic [COUNT_BITS-1:0] LIMIT_RESET    = COUNT_BITS'(SLOT_COUNT);
	localparam logic [WORD_BITS-1:0]  RESERVED_RESET = '1;

	typedef enum logic [1:0] {
		CMD_CREATE   = 2'd0,
		CMD_FIND_KEY = 2'd1,
		CMD_FIND_ID  = 2'd2,
		CMD_FREE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_NOT_FOUND  = 2'd2,
		STAT_NOT_ACTIVE = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_LIMIT    = 1'b0,
		CFG_RESERVED = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_ALLOC,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic eval;
		logic alloc;
		logic load_out;
	} pst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_create;
		logic create_go;
		logic cand_ok;
	} pst_stat_t;

	function automatic logic [WORD_BITS-1:0] ext_id(input logic [ID_BITS-1:0] v);
		return WORD_BITS'(v);
	endfunction

endpackage

@@ rtl/pst_ctrl.sv @@
// ----------------------------------------------------------------------------
// pst_ctrl
// command sequencer: accept, evaluate, id allocation loop, result hand-off
// ----------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pst_stat_t stat,
	output pst_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.is_create && stat.create_go) state_d = S_ALLOC;
				else state_d = S_DONE;
			end
			S_ALLOC: begin
				if (stat.cand_ok) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.load_item = (state_q == S_IDLE) && in_valid;
		cmd.eval      = (state_q == S_EVAL);
		cmd.alloc     = (state_q == S_ALLOC);
		cmd.load_out  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/pst_datapath.sv @@
// ----------------------------------------------------------------------------
// pst_datapath
// slot storage, parallel match logic, id candidate counter and result regs
// ----------------------------------------------------------------------------
module pst_datapath import pst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pst_cmd_t               cmd,
	output pst_stat_t              stat,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [WORD_BITS-1:0]   cfg_data,
	input  logic [1:0]             in_cmd,
	input  logic [SLOT_BITS-1:0]   in_slot,
	input  logic [WORD_BITS-1:0]   in_lookup_id,
	input  logic [WORD_BITS-1:0]   in_sess,
	input  logic signed [SEC_BITS-1:0]  in_sec,
	input  logic signed [WORD_BITS-1:0] in_nsec,
	output logic [1:0]             out_status,
	output logic [SLOT_BITS-1:0]   out_slot,
	output logic [WORD_BITS-1:0]   out_id,
	output logic [COUNT_BITS-1:0]  out_count
);

	// configuration
	logic [COUNT_BITS-1:0] limit_q;
	logic [WORD_BITS-1:0]  reserved_q;

	// latched item
	cmd_t                        item_cmd_q;
	logic [SLOT_BITS-1:0]        item_slot_q;
	logic [WORD_BITS-1:0]        item_lid_q;
	logic [WORD_BITS-1:0]        item_sess_q;
	logic signed [SEC_BITS-1:0]  item_sec_q;
	logic signed [WORD_BITS-1:0] item_nsec_q;

	// slot table
	logic                        active_q  [SLOT_COUNT];
	logic [ID_BITS-1:0]          peer_id_q [SLOT_COUNT];
	logic [WORD_BITS-1:0]        sess_q    [SLOT_COUNT];
	logic signed [SEC_BITS-1:0]  sec_q     [SLOT_COUNT];
	logic signed [WORD_BITS-1:0] nsec_q    [SLOT_COUNT];

	logic [COUNT_BITS-1:0] active_total_q;
	logic [ID_BITS-1:0]    next_cand_q;
	logic [ID_BITS-1:0]    cand_q;

	// pending result
	status_t              res_status_q;
	logic [SLOT_BITS-1:0] res_slot_q;
	logic [ID_BITS-1:0]   res_id_q;

	// output beat
	status_t               out_status_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic [WORD_BITS-1:0]  out_id_q;
	logic [COUNT_BITS-1:0] out_count_q;

	logic                 free_found, key_hit, id_hit, in_use, cand_ok;
	logic [SLOT_BITS-1:0] free_idx, key_idx, id_idx;

	// lowest-index searches over all slots
	always_comb begin
		free_found = 1'b0;
		key_hit    = 1'b0;
		id_hit     = 1'b0;
		in_use     = 1'b0;
		free_idx   = '0;
		key_idx    = '0;
		id_idx     = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_BITS'(i);
			end
			if (active_q[i] && sess_q[i] == item_sess_q && sec_q[i] == item_sec_q
					&& nsec_q[i] == item_nsec_q) begin
				key_hit = 1'b1;
				key_idx = SLOT_BITS'(i);
			end
			if (active_q[i] && ext_id(peer_id_q[i]) == item_lid_q) begin
				id_hit = 1'b1;
				id_idx = SLOT_BITS'(i);
			end
			if (active_q[i] && peer_id_q[i] == cand_q) in_use = 1'b1;
		end
	end

	assign cand_ok = (cand_q != '0) && (ext_id(cand_q) != reserved_q) && !in_use;

	assign stat.is_create = (item_cmd_q == CMD_CREATE);
	assign stat.create_go = (active_total_q < limit_q) && free_found;
	assign stat.cand_ok   = cand_ok;

	// control state: config, active bits, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= LIMIT_RESET;
			reserved_q     <= RESERVED_RESET;
			active_total_q <= '0;
			next_cand_q    <= ID_BITS'(1);
			for (int i = 0; i < SLOT_COUNT; i++) active_q[i] <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LIMIT:    limit_q    <= cfg_data[COUNT_BITS-1:0];
					CFG_RESERVED: reserved_q <= cfg_data;
					default:      ;
				endcase
			end
			if (cmd.eval && item_cmd_q == CMD_FREE && active_q[item_slot_q]) begin
				active_q[item_slot_q] <= 1'b0;
				if (active_total_q != '0) active_total_q <= active_total_q - COUNT_BITS'(1);
			end
			if (cmd.alloc && cand_ok) begin
				active_q[free_idx] <= 1'b1;
				active_total_q     <= active_total_q + COUNT_BITS'(1);
				next_cand_q        <= cand_q + ID_BITS'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_cmd_q  <= cmd_t'(in_cmd);
			item_slot_q <= in_slot;
			item_lid_q  <= in_lookup_id;
			item_sess_q <= in_sess;
			item_sec_q  <= in_sec;
			item_nsec_q <= in_nsec;
		end
		if (cmd.eval) begin
			res_status_q <= STAT_NOT_FOUND;
			res_slot_q   <= '0;
			res_id_q     <= '0;
			unique case (item_cmd_q)
				CMD_CREATE: begin
					cand_q <= next_cand_q;
					if (!stat.create_go) res_status_q <= STAT_FULL;
				end
				CMD_FIND_KEY: begin
					if (key_hit) begin
						res_status_q <= STAT_OK;
						res_slot_q   <= key_idx;
						res_id_q     <= peer_id_q[key_idx];
					end
				end
				CMD_FIND_ID: begin
					if (id_hit) begin
						res_status_q <= STAT_OK;
						res_slot_q   <= id_idx;
						res_id_q     <= peer_id_q[id_idx];
					end
				end
				CMD_FREE: begin
					res_status_q <= active_q[item_slot_q] ? STAT_OK : STAT_NOT_ACTIVE;
				end
				default: ;
			endcase
		end
		if (cmd.alloc) begin
			if (cand_ok) begin
				peer_id_q[free_idx] <= cand_q;
				sess_q[free_idx]    <= item_sess_q;
				sec_q[free_idx]     <= item_sec_q;
				nsec_q[free_idx]    <= item_nsec_q;
				res_status_q        <= STAT_OK;
				res_slot_q          <= free_idx;
				res_id_q            <= cand_q;
			end else begin
				cand_q <= cand_q + ID_BITS'(1);
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_id_q     <= ext_id(res_id_q);
			out_count_q  <= active_total_q;
		end
	end

	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_id     = out_id_q;
	assign out_count  = out_count_q;

endmodule

@@ rtl/peer_session_table.sv @@
// ----------------------------------------------------------------------------
// peer_session_table
// table of peer slots with session keys, id allocation, lookup and free
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one command beat: create,
//   find by session key, find by peer id or free slot. output channel
//   (out_valid/out_ready) returns exactly one result beat per command.
//   cfg_we writes the active-peer limit (index 0) or the reserved
//   broadcast id (index 1); the user must write only while the table is
//   idle, and the block itself does not enforce this. an accepted find or
//   free passes through the evaluate state to the done state, which loads
//   the output register once it is free; a create also passes through the
//   allocate state, which tries candidate ids and skips 0, the reserved
//   id, or an id held by an active slot. one command is in flight at a
//   time; the id candidate loop against all slots in parallel sets the
//   create time. in_ready rises again at the edge that moves the result into the output register.
//   reset clears all active bits, the active count and sets the next
//   candidate id to one; config returns to limit 16 and all-ones reserved.
//   a stalled output holds its beat; the next command may be accepted
//   meanwhile and waits in its final state until the output frees.
// ----------------------------------------------------------------------------
module peer_session_table import pst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [3:0]           slot_index,
	input  logic [31:0]          lookup_id,
	input  logic [31:0]          key_session,
	input  logic signed [63:0]   key_seconds,
	input  logic signed [31:0]   key_nanoseconds,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [3:0]           result_slot,
	output logic [31:0]          result_id,
	output logic [4:0]           active_count
);

	pst_cmd_t  ctl;
	pst_stat_t st;

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (st),
		.cmd       (ctl)
	);

	pst_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl),
		.stat         (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_cmd       (cmd),
		.in_slot      (slot_index),
		.in_lookup_id (lookup_id),
		.in_sess      (key_session),
		.in_sec       (key_seconds),
		.in_nsec      (key_nanoseconds),
		.out_status   (status),
		.out_slot     (result_slot),
		.out_id       (result_id),
		.out_count    (active_count)
	);

endmodule

@@ rtl/pst_checker.sv @@
// ----------------------------------------------------------------------------
// pst_checker
// port-level checks of the peer session table, bound to the top level
// ----------------------------------------------------------------------------
module pst_checker import pst_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [3:0]         result_slot,
	input logic [31:0]        result_id,
	input logic [4:0]         active_count
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_id)
			&& $stable(result_slot) && $stable(active_count))
		else $error("stalled result beat changed");

	// one command at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a beat while a command is in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count <= 5'(SLOT_COUNT))
		else $error("active count beyond table size");

	// failures carry no slot or id (successful frees are not checked here)
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> result_slot == '0 && result_id == '0)
		else $error("failed command returned a slot or id");

endmodule

bind peer_session_table pst_checker u_pst_checker (.*);

@@ dv/tb_peer_session_table.sv @@
// ----------------------------------------------------------------------------
// tb_peer_session_table
// self-checking bench for the peer session table
// ----------------------------------------------------------------------------
// a directed opening fills the table, overflows it, hits duplicate keys and
// frees and reuses slots. random phases then move the active-peer limit and
// the reserved broadcast id (including values the id counter is about to
// hit) while a mix of creates, lookups and frees runs under bursty input
// and a patterned output stall. every result beat is compared field by
// field against an in-bench copy of the table state.
// ----------------------------------------------------------------------------
module tb_peer_session_table;
	import pst_pkg::*;

	typedef struct packed {
		logic [31:0]        sess;
		logic signed [63:0] sec;
		logic signed [31:0] nsec;
	} sess_key_t;

	typedef struct packed {
		cmd_t        op;
		logic [3:0]  slot;
		logic [31:0] lid;
		sess_key_t   key;
	} tbl_cmd_t;

	typedef struct packed {
		status_t     st;
		logic [3:0]  slot;
		logic [31:0] id;
		logic [4:0]  count;
	} tbl_resp_t;

	localparam int IDLE_LIMIT  = 3000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 288;
	localparam int CHUNK       = 6;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [3:0]         slot_index;
	logic [31:0]        lookup_id;
	logic [31:0]        key_session;
	logic signed [63:0] key_seconds;
	logic signed [31:0] key_nanoseconds;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [3:0]         result_slot;
	logic [31:0]        result_id;
	logic [4:0]         active_count;

	peer_session_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.slot_index      (slot_index),
		.lookup_id       (lookup_id),
		.key_session     (key_session),
		.key_seconds     (key_seconds),
		.key_nanoseconds (key_nanoseconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.result_slot     (result_slot),
		.result_id       (result_id),
		.active_count    (active_count)
	);

	// shadow table
	logic [4:0]  lim_q;
	logic [31:0] rsv_q;
	logic        act_q [SLOT_COUNT];
	logic [31:0] pid_q [SLOT_COUNT];
	sess_key_t   key_q [SLOT_COUNT];
	logic [4:0]  total_q;
	logic [31:0] next_id_q;

	tbl_cmd_t  cmd_backlog [$];
	tbl_resp_t pending_resp [$];
	sess_key_t key_pool [4];

	int errors;
	int n_pushed;
	int n_items;
	int n_beats;
	int idle_cycles;
	int st_hist [4];

	logic in_taken;
	int   burst_left;
	int   gap_left;
	int   rx_left;
	int   rx_mode;
	int   rx_tick;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic apply_table_cmd(input tbl_cmd_t c, output tbl_resp_t r);
		int          free_slot;
		logic [31:0] cand;
		logic        got;
		logic        held;
		r.st   = STAT_NOT_FOUND;
		r.slot = '0;
		r.id   = '0;
		case (c.op)
			CMD_CREATE: begin
				r.st = STAT_FULL;
				free_slot = -1;
				if (total_q < lim_q) begin
					for (int i = SLOT_COUNT - 1; i >= 0; i--)
						if (!act_q[i]) free_slot = i;
					if (free_slot >= 0) begin
						cand = next_id_q;
						got  = 1'b0;
						// at most SLOT_COUNT + 1 unusable candidates in a row
						for (int t = 0; t < SLOT_COUNT + 3 && !got; t++) begin
							held = 1'b0;
							for (int i = 0; i < SLOT_COUNT; i++)
								if (act_q[i] && pid_q[i] == cand) held = 1'b1;
							if (cand != 0 && cand != rsv_q && !held) got = 1'b1;
							else cand = cand + 1;
						end
						if (got) begin
							pid_q[free_slot] = cand;
							key_q[free_slot] = c.key;
							act_q[free_slot] = 1'b1;
							next_id_q        = cand + 1;
							total_q          = total_q + 1;
							r.st             = STAT_OK;
							r.slot           = 4'(free_slot);
							r.id             = cand;
						end
					end
				end
			end
			CMD_FIND_KEY, CMD_FIND_ID: begin
				for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
					if (act_q[i] && ((c.op == CMD_FIND_KEY) ? (key_q[i] == c.key)
					                                        : (pid_q[i] == c.lid))) begin
						r.st   = STAT_OK;
						r.slot = 4'(i);
						r.id   = pid_q[i];
					end
				end
			end
			default: begin
				r.st = STAT_NOT_ACTIVE;
				if (act_q[c.slot]) begin
					act_q[c.slot] = 1'b0;
					if (total_q > 0) total_q = total_q - 1;
					r.st = STAT_OK;
				end
			end
		endcase
		r.count = total_q;
	endtask

	function automatic sess_key_t rand_key();
		sess_key_t k;
		case ($urandom_range(0, 3))
			0, 1:    k = key_pool[$urandom_range(0, 3)];
			default: k = {$urandom, $urandom, $urandom, $urandom};
		endcase
		return k;
	endfunction

	function automatic tbl_cmd_t gen_cmd(input int create_w);
		tbl_cmd_t c;
		int       pick;
		int       s;
		int       rest;
		pick  = $urandom_range(0, 99);
		s     = $urandom_range(0, SLOT_COUNT - 1);
		rest  = 100 - create_w;
		c.slot = 4'($urandom);
		c.lid  = $urandom;
		c.key  = rand_key();
		if (pick < create_w) begin
			c.op = CMD_CREATE;
		end else if (pick < create_w + rest / 3) begin
			c.op = CMD_FIND_KEY;
			case ($urandom_range(0, 3))
				0, 1:    c.key = key_q[s];
				2:       c.key = key_q[s] ^ (128'd1 << $urandom_range(0, 127));
				default: ;
			endcase
		end else if (pick < create_w + 2 * rest / 3) begin
			c.op = CMD_FIND_ID;
			case ($urandom_range(0, 3))
				0, 1:    c.lid = pid_q[s];
				2:       c.lid = next_id_q - 32'($urandom_range(0, 20));
				default: ;
			endcase
		end else begin
			c.op = CMD_FREE;
		end
		return c;
	endfunction

	task automatic push_cmd(input cmd_t op, input logic [3:0] slot, input logic [31:0] lid,
	                        input sess_key_t key);
		tbl_cmd_t c;
		c.op   = op;
		c.slot = slot;
		c.lid  = lid;
		c.key  = key;
		cmd_backlog.push_back(c);
		n_pushed++;
	endtask

	task automatic wait_results();
		while (n_beats < n_pushed) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// input driver, bursts and gaps
	always @(negedge clk) begin
		tbl_cmd_t c;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0 || cmd_backlog.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				c = cmd_backlog.pop_front();
				in_valid        <= 1'b1;
				cmd             <= c.op;
				slot_index      <= c.slot;
				lookup_id       <= c.lid;
				key_session     <= c.key.sess;
				key_seconds     <= c.key.sec;
				key_nanoseconds <= c.key.nsec;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// output stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (rx_tick % 8 == 0);
		endcase
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		tbl_cmd_t  c;
		tbl_resp_t e;
		tbl_resp_t r;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				n_beats++;
				r.st    = status_t'(status);
				r.slot  = result_slot;
				r.id    = result_id;
				r.count = active_count;
				if (pending_resp.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: st=%0d slot=%0d id=%h cnt=%0d",
						         r.st, r.slot, r.id, r.count);
				end else begin
					e = pending_resp.pop_front();
					st_hist[e.st]++;
					if (e.st != r.st || e.slot != r.slot || e.id != r.id || e.count != r.count) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st=%0d slot=%0d id=%h cnt=%0d, got st=%0d slot=%0d id=%h cnt=%0d",
							         e.st, e.slot, e.id, e.count, r.st, r.slot, r.id, r.count);
					end
				end
			end
			if (in_valid && in_ready) begin
				n_items++;
				c.op       = cmd_t'(cmd);
				c.slot     = slot_index;
				c.lid      = lookup_id;
				c.key.sess = key_session;
				c.key.sec  = key_seconds;
				c.key.nsec = key_nanoseconds;
				apply_table_cmd(c, e);
				pending_resp.push_back(e);
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		int          phase_limit [PHASES];
		int          phase_create [PHASES];
		logic [4:0]  lim_new;
		logic [31:0] rsv_new;
		logic        rsv_first;
		sess_key_t   k;

		phase_limit  = '{16, 1, 31, 0, -1, 16};
		phase_create = '{40, 35, 45, 30, 40, 50};

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		cmd             = '0;
		slot_index      = '0;
		lookup_id       = '0;
		key_session     = '0;
		key_seconds     = '0;
		key_nanoseconds = '0;
		out_ready       = 1'b0;
		in_taken        = 1'b0;

		lim_q     = LIMIT_RESET;
		rsv_q     = RESERVED_RESET;
		total_q   = '0;
		next_id_q = 32'd1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			act_q[i] = 1'b0;
			pid_q[i] = '0;
			key_q[i] = '0;
		end
		key_pool[0] = '0;
		key_pool[1] = {32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000};
		key_pool[2] = {$urandom, $urandom, $urandom, $urandom};
		key_pool[3] = {$urandom, $urandom, $urandom, $urandom};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening under reset settings
		push_cmd(CMD_FREE, 4'd0, '0, '0);
		push_cmd(CMD_FIND_ID, 4'd0, 32'd0, '0);
		push_cmd(CMD_FIND_KEY, 4'd0, '0, key_pool[1]);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			case (i)
				0, 3:    k = key_pool[0];
				1:       k = key_pool[1];
				2:       k = {32'h0, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF};
				default: k = {$urandom, $urandom, $urandom, $urandom};
			endcase
			push_cmd(CMD_CREATE, 4'($urandom), $urandom, k);
		end
		push_cmd(CMD_CREATE, 4'd0, '0, key_pool[2]);
		push_cmd(CMD_FIND_KEY, 4'd0, '0, key_pool[0]);
		push_cmd(CMD_FIND_ID, 4'd0, 32'd16, '0);
		push_cmd(CMD_FREE, 4'd0, '0, '0);
		push_cmd(CMD_FIND_KEY, 4'd0, '0, key_pool[0]);
		push_cmd(CMD_CREATE, 4'd15, 32'hFFFF_FFFF, key_pool[3]);
		wait_results();

		for (int p = 0; p < PHASES; p++) begin
			lim_new = (phase_limit[p] < 0) ? 5'($urandom_range(1, 16)) : 5'(phase_limit[p]);
			case (p)
				0:       rsv_new = next_id_q + 1;
				1:       rsv_new = '0;
				2:       rsv_new = next_id_q;
				3:       rsv_new = $urandom;
				4:       rsv_new = '1;
				default: rsv_new = next_id_q + 3;
			endcase
			rsv_first = 1'($urandom_range(0, 1));
			for (int w = 0; w < 2; w++) begin
				@(negedge clk);
				cfg_we <= 1'b1;
				if (w[0] ^ rsv_first) begin
					cfg_index <= CFG_LIMIT;
					cfg_data  <= 32'(lim_new);
				end else begin
					cfg_index <= CFG_RESERVED;
					cfg_data  <= rsv_new;
				end
			end
			@(negedge clk);
			cfg_we <= 1'b0;
			lim_q = lim_new;
			rsv_q = rsv_new;

			for (int n = 0; n < PHASE_ITEMS; n += CHUNK) begin
				while (cmd_backlog.size() > 2) @(posedge clk);
				for (int j = 0; j < CHUNK; j++) begin
					cmd_backlog.push_back(gen_cmd(phase_create[p]));
					n_pushed++;
				end
			end
			wait_results();
		end

		repeat (30) @(posedge clk);
		$display("run covered %0d commands over %0d table settings; %0d result beats checked",
		         n_items, PHASES + 1, n_beats);
		$display("outcomes: ok %0d, full %0d, not found %0d, not active %0d; failures %0d",
		         st_hist[STAT_OK], st_hist[STAT_FULL], st_hist[STAT_NOT_FOUND],
		         st_hist[STAT_NOT_ACTIVE], errors);
		if (errors == 0 && pending_resp.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
